/* src/tli_pkg.sv */
// ----------------------------------------------------------------------------
// Table Lagrange interpolator package
// Shared types, codes and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int XW     = 32;   // Q16.16 word
    localparam int ORD_W  = 4;    // order up to 15
    localparam int J_W    = ORD_W + 1;
    localparam int MUL_W  = 33;   // |xq - xj| and |xi - xj| magnitudes
    localparam int PROD_W = 93;   // 60-bit magnitude times 33-bit factor
    localparam int MAG_W  = 60;
    localparam int SUM_W  = 64;
    localparam int CNT_W  = 7;
    localparam int MUL_LAST = MUL_W - 1;
    localparam int DIV_LAST = PROD_W - 1;

    localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(64'h0800_0000_0000_0000);
    localparam logic [MAG_W-1:0]  MAG_CAP  = MAG_W'(64'h0800_0000_0000_0000);

    localparam logic OPER_WRITE = 1'b0;
    localparam logic OPER_QUERY = 1'b1;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_ZERO_DEN = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic REG_POINT_COUNT  = 1'b0;
    localparam logic REG_INTERP_ORDER = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [7:0]           point_index;
        logic signed [XW-1:0] x_value;
        logic signed [XW-1:0] f_value;
    } in_item_t;

    typedef struct packed {
        logic signed [XW-1:0] result_value;
        logic [1:0]           status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_FIRST,
        OP_RD_LAST,
        OP_RANGE,
        OP_SRCH_RD,
        OP_SRCH_UPD,
        OP_WINDOW,
        OP_RD_J,
        OP_J_INC,
        OP_RD_I,
        OP_LOAD_I,
        OP_RES_HIT,
        OP_RES_DUP,
        OP_MAG_INIT,
        OP_FACTOR,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_ACC,
        OP_FINISH,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_RANGE,
        S_SRCH,
        S_SRCH_CMP,
        S_WINDOW,
        S_HIT_RD,
        S_HIT_CMP,
        S_XI_RD,
        S_XI_LD,
        S_DUP_RD,
        S_DUP_CMP,
        S_MAG,
        S_FAC_RD,
        S_FAC_LD,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_ACC,
        S_FINISH,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic range_end;
        logic search_done;
        logic j_over;
        logic j_is_i;
        logic hit;
        logic dup;
        logic i_last;
        logic mul_last;
        logic div_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* src/tli_ctrl.sv */
// ----------------------------------------------------------------------------
// Table Lagrange interpolator controller
// Sequences lookup, window selection and the term-by-term multiply/divide.
// ----------------------------------------------------------------------------
module tli_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_operation,
    output logic                s_ready,
    input  tli_pkg::dp_status_t st,
    output tli_pkg::dp_op_t     op
);

    tli_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tli_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = tli_pkg::OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            tli_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op = tli_pkg::OP_ACCEPT;
                    if (s_operation == tli_pkg::OPER_QUERY) begin
                        state_next = tli_pkg::S_RD_FIRST;
                    end
                end
            end
            tli_pkg::S_RD_FIRST: begin
                op = tli_pkg::OP_RD_FIRST;
                state_next = tli_pkg::S_RD_LAST;
            end
            tli_pkg::S_RD_LAST: begin
                op = tli_pkg::OP_RD_LAST;
                state_next = tli_pkg::S_RANGE;
            end
            tli_pkg::S_RANGE: begin
                op = tli_pkg::OP_RANGE;
                state_next = st.range_end ? tli_pkg::S_OUT : tli_pkg::S_SRCH;
            end
            tli_pkg::S_SRCH: begin
                if (st.search_done) begin
                    state_next = tli_pkg::S_WINDOW;
                end else begin
                    op = tli_pkg::OP_SRCH_RD;
                    state_next = tli_pkg::S_SRCH_CMP;
                end
            end
            tli_pkg::S_SRCH_CMP: begin
                op = tli_pkg::OP_SRCH_UPD;
                state_next = tli_pkg::S_SRCH;
            end
            tli_pkg::S_WINDOW: begin
                op = tli_pkg::OP_WINDOW;
                state_next = tli_pkg::S_HIT_RD;
            end
            tli_pkg::S_HIT_RD: begin
                if (st.j_over) begin
                    state_next = tli_pkg::S_XI_RD;
                end else begin
                    op = tli_pkg::OP_RD_J;
                    state_next = tli_pkg::S_HIT_CMP;
                end
            end
            tli_pkg::S_HIT_CMP: begin
                if (st.hit) begin
                    op = tli_pkg::OP_RES_HIT;
                    state_next = tli_pkg::S_OUT;
                end else begin
                    op = tli_pkg::OP_J_INC;
                    state_next = tli_pkg::S_HIT_RD;
                end
            end
            tli_pkg::S_XI_RD: begin
                op = tli_pkg::OP_RD_I;
                state_next = tli_pkg::S_XI_LD;
            end
            tli_pkg::S_XI_LD: begin
                op = tli_pkg::OP_LOAD_I;
                state_next = tli_pkg::S_DUP_RD;
            end
            tli_pkg::S_DUP_RD: begin
                if (st.j_over) begin
                    state_next = tli_pkg::S_MAG;
                end else begin
                    op = tli_pkg::OP_RD_J;
                    state_next = tli_pkg::S_DUP_CMP;
                end
            end
            tli_pkg::S_DUP_CMP: begin
                if (st.dup) begin
                    op = tli_pkg::OP_RES_DUP;
                    state_next = tli_pkg::S_OUT;
                end else begin
                    op = tli_pkg::OP_J_INC;
                    state_next = tli_pkg::S_DUP_RD;
                end
            end
            tli_pkg::S_MAG: begin
                op = tli_pkg::OP_MAG_INIT;
                state_next = tli_pkg::S_FAC_RD;
            end
            tli_pkg::S_FAC_RD: begin
                if (st.j_over) begin
                    state_next = tli_pkg::S_ACC;
                end else if (st.j_is_i) begin
                    op = tli_pkg::OP_J_INC;   // skip own point
                end else begin
                    op = tli_pkg::OP_RD_J;
                    state_next = tli_pkg::S_FAC_LD;
                end
            end
            tli_pkg::S_FAC_LD: begin
                op = tli_pkg::OP_FACTOR;
                state_next = tli_pkg::S_MUL;
            end
            tli_pkg::S_MUL: begin
                op = tli_pkg::OP_MUL_STEP;
                if (st.mul_last) begin
                    state_next = tli_pkg::S_DIV_INIT;
                end
            end
            tli_pkg::S_DIV_INIT: begin
                op = tli_pkg::OP_DIV_INIT;
                state_next = tli_pkg::S_DIV;
            end
            tli_pkg::S_DIV: begin
                op = tli_pkg::OP_DIV_STEP;
                if (st.div_last) begin
                    state_next = tli_pkg::S_DIV_END;
                end
            end
            tli_pkg::S_DIV_END: begin
                op = tli_pkg::OP_DIV_END;
                state_next = tli_pkg::S_FAC_RD;
            end
            tli_pkg::S_ACC: begin
                op = tli_pkg::OP_ACC;
                state_next = st.i_last ? tli_pkg::S_FINISH : tli_pkg::S_HIT_RD;
            end
            tli_pkg::S_FINISH: begin
                op = tli_pkg::OP_FINISH;
                state_next = tli_pkg::S_OUT;
            end
            tli_pkg::S_OUT: begin
                if (!st.out_busy) begin
                    op = tli_pkg::OP_OUT;
                    state_next = tli_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tli_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* src/tli_dp.sv */
// ----------------------------------------------------------------------------
// Table Lagrange interpolator datapath
// Point tables, search and window registers, shift-add multiplier,
// restoring divider, term accumulator and output register.
// ----------------------------------------------------------------------------
module tli_dp #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_ORDER   = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tli_pkg::dp_op_t     op,
    input  tli_pkg::in_item_t   in_item,
    input  logic [8:0]          cfg_count,
    input  logic [2:0]          cfg_order,
    output tli_pkg::dp_status_t st,
    output logic                m_valid,
    input  logic                m_ready,
    output tli_pkg::out_item_t  m_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int XW = tli_pkg::XW;

    logic [XW-1:0] mem_x [TABLE_DEPTH];
    logic [XW-1:0] mem_f [TABLE_DEPTH];

    logic signed [XW-1:0] rd_x_reg, rd_f_reg;
    logic signed [XW-1:0] xq_reg, x0_reg, f0_reg, xi_reg, fi_reg;
    logic                 asc_reg;
    logic [AW-1:0]        lo_reg, hi_reg, off_reg;
    logic [tli_pkg::ORD_W-1:0] ord_reg, i_reg;
    logic [tli_pkg::J_W-1:0]   j_reg;
    logic [tli_pkg::MAG_W-1:0] mag_reg;
    logic                 neg_reg, sat_reg;
    logic signed [tli_pkg::SUM_W-1:0] sum_reg;
    logic [tli_pkg::PROD_W-1:0] mcand_reg, prod_reg;
    logic [tli_pkg::MUL_W-1:0]  mplier_reg, de_reg, rem_reg;
    logic [tli_pkg::CNT_W-1:0]  cnt_reg;
    tli_pkg::out_item_t   res_reg, out_reg;
    logic                 m_valid_reg;

    // effective count, clamped to 1..TABLE_DEPTH
    logic [NW-1:0] n_eff;
    always_comb begin
        if (cfg_count == 9'd0) begin
            n_eff = NW'(1);
        end else if (int'(cfg_count) > TABLE_DEPTH) begin
            n_eff = NW'(TABLE_DEPTH);
        end else begin
            n_eff = NW'(cfg_count);
        end
    end

    logic [AW-1:0] mid, addr_j, addr_i, rd_addr, last_addr;
    logic          wr_en;
    assign mid       = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign addr_j    = AW'(int'(off_reg) + int'(j_reg));
    assign addr_i    = AW'(int'(off_reg) + int'(i_reg));
    assign last_addr = AW'(n_eff - NW'(1));
    assign wr_en     = (op == tli_pkg::OP_ACCEPT)
                    && (in_item.operation == tli_pkg::OPER_WRITE)
                    && (int'(in_item.point_index) < TABLE_DEPTH);

    always_comb begin
        case (op)
            tli_pkg::OP_RD_LAST: rd_addr = last_addr;
            tli_pkg::OP_SRCH_RD: rd_addr = mid;
            tli_pkg::OP_RD_J:    rd_addr = addr_j;
            tli_pkg::OP_RD_I:    rd_addr = addr_i;
            default:             rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[AW'(in_item.point_index)] <= in_item.x_value;
            mem_f[AW'(in_item.point_index)] <= in_item.f_value;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_f_reg <= mem_f[rd_addr];
    end

    // range decision; rd holds the last point here
    logic single, asc, low_end, high_end, go_hi;
    assign single   = (n_eff == NW'(1));
    assign asc      = x0_reg < rd_x_reg;
    assign low_end  = asc ? (xq_reg < x0_reg) : (xq_reg > x0_reg);
    assign high_end = asc ? (xq_reg > rd_x_reg) : (xq_reg < rd_x_reg);
    assign go_hi    = asc_reg ? (xq_reg < rd_x_reg) : (xq_reg > rd_x_reg);

    // window placement around the bracketing pair
    logic [tli_pkg::ORD_W-1:0] ord_w;
    logic [AW-1:0]             off_w;
    always_comb begin
        int ord_i, half, off_i, lim;
        ord_i = int'(cfg_order);
        if (ord_i > MAX_ORDER) ord_i = MAX_ORDER;
        if (ord_i > int'(n_eff) - 1) ord_i = int'(n_eff) - 1;
        half = (ord_i > 0) ? ((ord_i - 1) >>> 1) : 0;
        off_i = int'(lo_reg) - half;
        if (off_i < 0) off_i = 0;
        lim = int'(n_eff) - ord_i - 1;
        if (off_i > lim) off_i = lim;
        if (off_i < 0) off_i = 0;
        ord_w = tli_pkg::ORD_W'(ord_i);
        off_w = AW'(off_i);
    end

    // factor operands
    logic signed [XW:0] nu_s, de_s;
    logic [XW-1:0]      fi_abs;
    assign nu_s   = {xq_reg[XW-1], xq_reg} - {rd_x_reg[XW-1], rd_x_reg};
    assign de_s   = {xi_reg[XW-1], xi_reg} - {rd_x_reg[XW-1], rd_x_reg};
    assign fi_abs = fi_reg[XW-1] ? (-fi_reg) : fi_reg;

    // divider step
    logic [tli_pkg::MUL_W:0] rem_sh;
    logic                    ge;
    assign rem_sh = {rem_reg, prod_reg[tli_pkg::PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, de_reg};

    // term and final result
    logic signed [tli_pkg::SUM_W-1:0] term;
    logic [tli_pkg::SUM_W-1:0]        sum_abs;
    logic [47:0]                      q_abs;
    logic [XW-1:0]                    q_sat;
    logic                             fin_sat;
    assign term    = $signed({{(tli_pkg::SUM_W - tli_pkg::MAG_W){1'b0}}, mag_reg});
    assign sum_abs = sum_reg[tli_pkg::SUM_W-1] ? 64'(-sum_reg) : 64'(sum_reg);
    assign q_abs   = sum_abs[63:16];
    always_comb begin
        fin_sat = 1'b0;
        q_sat   = q_abs[XW-1:0];
        if (!sum_reg[tli_pkg::SUM_W-1] && q_abs > 48'h0000_7FFF_FFFF) begin
            q_sat   = 32'h7FFF_FFFF;
            fin_sat = 1'b1;
        end else if (sum_reg[tli_pkg::SUM_W-1] && q_abs > 48'h0000_8000_0000) begin
            q_sat   = 32'h8000_0000;
            fin_sat = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            tli_pkg::OP_ACCEPT: begin
                xq_reg <= in_item.x_value;
            end
            tli_pkg::OP_RD_LAST: begin
                x0_reg <= rd_x_reg;
                f0_reg <= rd_f_reg;
            end
            tli_pkg::OP_RANGE: begin
                if (single || low_end) begin
                    res_reg <= '{result_value: f0_reg, status: tli_pkg::ST_RANGE};
                end else begin
                    res_reg <= '{result_value: rd_f_reg, status: tli_pkg::ST_RANGE};
                end
                lo_reg  <= '0;
                hi_reg  <= last_addr;
                asc_reg <= asc;
            end
            tli_pkg::OP_SRCH_UPD: begin
                if (go_hi) begin
                    hi_reg <= mid;
                end else begin
                    lo_reg <= mid;
                end
            end
            tli_pkg::OP_WINDOW: begin
                ord_reg <= ord_w;
                off_reg <= off_w;
                i_reg   <= '0;
                j_reg   <= '0;
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end
            tli_pkg::OP_J_INC: begin
                j_reg <= j_reg + 1'b1;
            end
            tli_pkg::OP_RD_I: begin
                j_reg <= '0;
            end
            tli_pkg::OP_LOAD_I: begin
                xi_reg <= rd_x_reg;
                fi_reg <= rd_f_reg;
            end
            tli_pkg::OP_RES_HIT: begin
                res_reg <= '{result_value: rd_f_reg, status: tli_pkg::ST_INTERP};
            end
            tli_pkg::OP_RES_DUP: begin
                res_reg <= '{result_value: '0, status: tli_pkg::ST_ZERO_DEN};
            end
            tli_pkg::OP_MAG_INIT: begin
                neg_reg <= fi_reg[XW-1];
                mag_reg <= {12'b0, fi_abs, 16'b0};
                j_reg   <= '0;
            end
            tli_pkg::OP_FACTOR: begin
                neg_reg    <= neg_reg ^ nu_s[XW] ^ de_s[XW];
                mplier_reg <= nu_s[XW] ? tli_pkg::MUL_W'(-nu_s) : tli_pkg::MUL_W'(nu_s);
                de_reg     <= de_s[XW] ? tli_pkg::MUL_W'(-de_s) : tli_pkg::MUL_W'(de_s);
                mcand_reg  <= tli_pkg::PROD_W'(mag_reg);
                prod_reg   <= '0;
                cnt_reg    <= '0;
            end
            tli_pkg::OP_MUL_STEP: begin
                if (mplier_reg[0]) begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            tli_pkg::OP_DIV_INIT: begin
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            tli_pkg::OP_DIV_STEP: begin
                rem_reg  <= ge ? tli_pkg::MUL_W'(rem_sh - {1'b0, de_reg})
                               : rem_sh[tli_pkg::MUL_W-1:0];
                prod_reg <= {prod_reg[tli_pkg::PROD_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            tli_pkg::OP_DIV_END: begin
                if (prod_reg > tli_pkg::TERM_CAP) begin
                    mag_reg <= tli_pkg::MAG_CAP;
                    sat_reg <= 1'b1;
                end else begin
                    mag_reg <= prod_reg[tli_pkg::MAG_W-1:0];
                end
                j_reg <= j_reg + 1'b1;
            end
            tli_pkg::OP_ACC: begin
                sum_reg <= neg_reg ? (sum_reg - term) : (sum_reg + term);
                i_reg   <= i_reg + 1'b1;
                j_reg   <= '0;
            end
            tli_pkg::OP_FINISH: begin
                res_reg.result_value <= sum_reg[tli_pkg::SUM_W-1] ? (-q_sat) : q_sat;
                res_reg.status <= (sat_reg || fin_sat) ? tli_pkg::ST_SAT : tli_pkg::ST_INTERP;
            end
            tli_pkg::OP_OUT: begin
                out_reg <= res_reg;
            end
            default: begin
            end
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (op == tli_pkg::OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign st.range_end   = single || low_end || high_end;
    assign st.search_done = ({1'b0, hi_reg} - {1'b0, lo_reg}) <= NW'(1);
    assign st.j_over      = j_reg > {1'b0, ord_reg};
    assign st.j_is_i      = j_reg == {1'b0, i_reg};
    assign st.hit         = (j_reg != {1'b0, i_reg}) && (rd_x_reg == xq_reg);
    assign st.dup         = (j_reg != {1'b0, i_reg}) && (rd_x_reg == xi_reg);
    assign st.i_last      = i_reg == ord_reg;
    assign st.mul_last    = cnt_reg == tli_pkg::CNT_W'(tli_pkg::MUL_LAST);
    assign st.div_last    = cnt_reg == tli_pkg::CNT_W'(tli_pkg::DIV_LAST);
    assign st.out_busy    = m_valid_reg && !m_ready;

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == tli_pkg::OP_OUT) |-> !(m_valid_reg && !m_ready))
        else $error("result loaded over an untaken transaction");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == tli_pkg::OP_DIV_STEP) |-> (de_reg != '0))
        else $error("divide by zero in term evaluation");

    a_window_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == tli_pkg::OP_RD_J || op == tli_pkg::OP_RD_I) |-> ({1'b0, rd_addr} < n_eff))
        else $error("window read beyond point count");

endmodule

/* src/table_lagrange_interpolator.sv */
// ----------------------------------------------------------------------------
// Table Lagrange interpolator
// Write transactions fill an (x, f) table; query transactions return the
// Lagrange interpolation over a window of order+1 points around the query.
//
// s_ channel: valid/ready, one in_item_t per transaction. A write transaction
//   (operation 0) stores one point in the accept cycle and gives no result;
//   writes are taken one per cycle while no query is in flight.
// m_ channel: valid/ready, one out_item_t per query transaction.
// APB port: register 0 point_count, register 4 interp_order; pready is high.
// Query sequence: end checks and a binary search, then per window point
//   hit and duplicate scans and order factors, each a shift-add multiply
//   and a restoring divide. Both point tables share one registered read port.
// One query is in flight at a time; the next transaction is accepted once the
//   result is in the output register.
// Reset clears the controller, the output valid and the registers
//   (point_count 1, interp_order 1); table contents are kept. When the
//   receiver stalls the result holds in the output register, and a finished
//   query waits for it to drain.
// ----------------------------------------------------------------------------
module table_lagrange_interpolator #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_ORDER   = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tli_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tli_pkg::out_item_t m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [8:0] count_reg;
    logic [2:0] order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 9'd1;
            order_reg <= 3'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tli_pkg::REG_INTERP_ORDER) begin
                order_reg <= pwdata[2:0];
            end else begin
                count_reg <= pwdata[8:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tli_pkg::REG_INTERP_ORDER) ? {29'b0, order_reg}
                                                          : {23'b0, count_reg};

    tli_pkg::dp_op_t     op;
    tli_pkg::dp_status_t st;

    tli_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_item.operation),
        .s_ready     (s_ready),
        .st          (st),
        .op          (op)
    );

    tli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_ORDER   (MAX_ORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .in_item   (s_item),
        .cfg_count (count_reg),
        .cfg_order (order_reg),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
